>>> src/ldu_pkg.sv
// Shared types, widths and codes for the LDU sparse matrix-vector block.
// Used by ldu_mul_unit, ldu_x_bank, ldu_acc_bank and ldu_sparse_matvec.
package ldu_pkg;

   // Number of cells held on chip and the address width of the stores.
   localparam int MAX_CELLS = 1024;
   localparam int ADDR_W    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

   // Field widths.
   localparam int CELL_W = 10;
   localparam int VAL_W  = 32;
   localparam int ACC_W  = 48;
   localparam int FRAC_W = 16;
   localparam int PROD_W = 2 * VAL_W;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MATRIX_KIND      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INCLUDE_DIAGONAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSPOSE        = 2'd2;

   // Item modes.
   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_FACE = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;

   // Matrix kinds.
   localparam logic [1:0] KIND_DIAG       = 2'd0;
   localparam logic [1:0] KIND_SYM_UPPER  = 2'd1;
   localparam logic [1:0] KIND_SYM_LOWER  = 2'd2;
   localparam logic [1:0] KIND_ASYMMETRIC = 2'd3;

   // Control word for the accumulator bank.
   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic              load;   // start from the initial value and clear the sticky flag
      logic [ADDR_W-1:0] addr;
   } acc_ctl_type;

   // Control word for the x bank.
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr_a;
      logic [ADDR_W-1:0] rd_addr_b;
   } x_ctl_type;

endpackage

>>> src/ldu_mul_unit.sv
// Shared Q16.16 by Q16.16 multiplier with a registered Q32.16 result.
// Depends on ldu_pkg.
module ldu_mul_unit (
   input  logic                             clock,
   input  logic                             en,
   input  logic signed [ldu_pkg::VAL_W-1:0] a,
   input  logic signed [ldu_pkg::VAL_W-1:0] b,
   output logic signed [ldu_pkg::ACC_W-1:0] prod
);
   import ldu_pkg::*;

   logic signed [PROD_W-1:0] full;
   logic signed [ACC_W-1:0]  prod_ff;

   // The arithmetic shift by the fraction width rounds toward minus infinity.
   assign full = a * b;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= full[FRAC_W +: ACC_W];
      end
   end

   assign prod = prod_ff;

endmodule

>>> src/ldu_x_bank.sv
// Vector store: one write port and two registered read ports.
// Depends on ldu_pkg.
module ldu_x_bank (
   input  logic                             clock,
   input  ldu_pkg::x_ctl_type               ctl,
   input  logic signed [ldu_pkg::VAL_W-1:0] wr_data,
   output logic signed [ldu_pkg::VAL_W-1:0] rd_data_a,
   output logic signed [ldu_pkg::VAL_W-1:0] rd_data_b
);
   import ldu_pkg::*;

   logic [VAL_W-1:0] mem [MAX_CELLS];
   logic [VAL_W-1:0] rd_a_ff;
   logic [VAL_W-1:0] rd_b_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= wr_data;
      end
   end

   // Read ports; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_a_ff <= mem[ctl.rd_addr_a];
         rd_b_ff <= mem[ctl.rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> src/ldu_acc_bank.sv
// Accumulator store with sticky saturation flags and a saturating adder
// for read-modify-write updates. Depends on ldu_pkg.
module ldu_acc_bank (
   input  logic                             clock,
   input  ldu_pkg::acc_ctl_type             ctl,
   input  logic signed [ldu_pkg::ACC_W-1:0] term,
   input  logic signed [ldu_pkg::ACC_W-1:0] init,
   output logic signed [ldu_pkg::ACC_W-1:0] rd_acc,
   output logic                             rd_sat
);
   import ldu_pkg::*;

   localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   // Each word holds the sticky flag above the accumulator.
   logic [ACC_W:0]   mem [MAX_CELLS];
   logic [ACC_W:0]   rd_ff;
   logic [ACC_W-1:0] base;
   logic [ACC_W:0]   sum;
   logic             ovf;
   logic [ACC_W-1:0] sum_sat;
   logic             sticky;

   // Saturating add of the term onto the stored or the initial value.
   always_comb begin
      base = ctl.load ? init : rd_ff[ACC_W-1:0];
      sum  = {base[ACC_W-1], base} + {term[ACC_W-1], term};
      ovf  = sum[ACC_W] ^ sum[ACC_W-1];
      if (ovf) begin
         sum_sat = sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         sum_sat = sum[ACC_W-1:0];
      end
      sticky = (ctl.load ? 1'b0 : rd_ff[ACC_W]) | ovf;
   end

   // Write port.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.addr] <= {sticky, sum_sat};
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_ff <= mem[ctl.addr];
      end
   end

   assign rd_acc = rd_ff[ACC_W-1:0];
   assign rd_sat = rd_ff[ACC_W];

endmodule

>>> src/ldu_sparse_matvec.sv
// LDU face-addressed sparse matrix-vector product, top level with sequencer.
// Depends on ldu_pkg, ldu_mul_unit, ldu_x_bank and ldu_acc_bank.
//
// Usage:
//   The req_ channel takes one word per item: a load, a face or a read.
//   Load words store x and start the cell's accumulator, adding diag * x
//   when the diagonal is enabled. Face words add a coefficient times the
//   opposite cell's x to both cells. Read words return one rsp_ word with
//   the cell's sum and its sticky overflow flag; loads and faces return none.
//   A load multiplies and writes; a read reads and outputs. A face reads x,
//   multiplies and writes the upper cell, then reads and writes the lower
//   cell: with one shared multiplier and one read/write port on the
//   accumulator memory, each face is two read-modify-write passes. Under the
//   diagonal kind a face is dropped. req_stall is high until the item is done.
//   The rsp_ word sits in an output register; while rsp_stall is high it
//   holds, and a following read waits in its last step until it is taken.
//   Reset clears the sequencer, the output valid and the csr_ registers
//   (matrix kind 0, diagonal on, transpose off). The cell stores are not
//   cleared: every cell must be loaded before a face or read touches it.
//   csr_ writes are always ready and are meant for idle periods only.
module ldu_sparse_matvec (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input item channel.
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_mode,
   input  logic [ldu_pkg::CELL_W-1:0]            req_cell_index,
   input  logic [ldu_pkg::CELL_W-1:0]            req_lower_cell,
   input  logic [ldu_pkg::CELL_W-1:0]            req_upper_cell,
   input  logic signed [ldu_pkg::VAL_W-1:0]      req_diag_value,
   input  logic signed [ldu_pkg::VAL_W-1:0]      req_x_value,
   input  logic signed [ldu_pkg::ACC_W-1:0]      req_acc_init,
   input  logic signed [ldu_pkg::VAL_W-1:0]      req_lower_coeff,
   input  logic signed [ldu_pkg::VAL_W-1:0]      req_upper_coeff,
   // Result channel.
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [ldu_pkg::CELL_W-1:0]            rsp_read_cell,
   output logic signed [ldu_pkg::ACC_W-1:0]      rsp_acc_value,
   output logic                                  rsp_overflow,
   // Configuration write channel.
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ldu_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ldu_pkg::CSR_DATA_W-1:0]        csr_data
);
   import ldu_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD_MUL,
      ST_LOAD_WR,
      ST_FACE_RDX,
      ST_FACE_MUL1,
      ST_FACE_WR1,
      ST_FACE_RD2,
      ST_FACE_WR2,
      ST_READ_RD,
      ST_READ_OUT
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [1:0] kind_ff;
   logic       incl_diag_ff;
   logic       transpose_ff;

   // Captured item.
   logic [CELL_W-1:0]       cell_ff;
   logic [CELL_W-1:0]       lc_ff;
   logic [CELL_W-1:0]       uc_ff;
   logic signed [VAL_W-1:0] diag_ff;
   logic signed [VAL_W-1:0] x_ff;
   logic signed [ACC_W-1:0] init_ff;
   logic signed [VAL_W-1:0] lo_ff;
   logic signed [VAL_W-1:0] up_ff;

   // Result register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]       rsp_cell_ff;
   logic signed [ACC_W-1:0] rsp_acc_ff;
   logic                    rsp_ovf_ff;

   logic req_take;
   logic rsp_take;
   logic rsp_free;
   logic cell_ok, lc_ok, uc_ok;

   logic signed [VAL_W-1:0] cu, cl;
   logic signed [VAL_W-1:0] xl, xu;
   logic signed [VAL_W-1:0] mul_a, mul_b;
   logic                    mul_en;
   logic signed [ACC_W-1:0] prod;
   logic signed [ACC_W-1:0] acc_term;
   logic signed [VAL_W-1:0] x_rd_a, x_rd_b;
   logic signed [ACC_W-1:0] acc_rd;
   logic                    sat_rd;

   x_ctl_type   x_ctl;
   acc_ctl_type acc_ctl;

   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // Cells at or beyond the store depth are outside the matrix.
   assign cell_ok = (32'(cell_ff) < MAX_CELLS);
   assign lc_ok   = (32'(lc_ff) < MAX_CELLS);
   assign uc_ok   = (32'(uc_ff) < MAX_CELLS);

   // Configuration writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= KIND_DIAG;
         incl_diag_ff <= 1'b1;
         transpose_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MATRIX_KIND:      kind_ff      <= csr_data[1:0];
            CSR_INCLUDE_DIAGONAL: incl_diag_ff <= csr_data[0];
            CSR_TRANSPOSE:        transpose_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Coefficient roles for the two updates of a face.
   always_comb begin
      case (kind_ff)
         KIND_SYM_UPPER: begin
            cu = up_ff;
            cl = up_ff;
         end
         KIND_SYM_LOWER: begin
            cu = lo_ff;
            cl = lo_ff;
         end
         default: begin
            cu = transpose_ff ? up_ff : lo_ff;
            cl = transpose_ff ? lo_ff : up_ff;
         end
      endcase
   end

   // A face to a cell outside the matrix sees zero for its x.
   assign xl = lc_ok ? x_rd_a : '0;
   assign xu = uc_ok ? x_rd_b : '0;

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_mode)
                  MODE_LOAD: state_in = ST_LOAD_MUL;
                  MODE_FACE: state_in = (kind_ff == KIND_DIAG) ? ST_IDLE : ST_FACE_RDX;
                  MODE_READ: state_in = ST_READ_RD;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOAD_MUL:  state_in = ST_LOAD_WR;
         ST_LOAD_WR:   state_in = ST_IDLE;
         ST_FACE_RDX:  state_in = ST_FACE_MUL1;
         ST_FACE_MUL1: state_in = ST_FACE_WR1;
         ST_FACE_WR1:  state_in = ST_FACE_RD2;
         ST_FACE_RD2:  state_in = ST_FACE_WR2;
         ST_FACE_WR2:  state_in = ST_IDLE;
         ST_READ_RD:   state_in = ST_READ_OUT;
         ST_READ_OUT:  state_in = rsp_free ? ST_IDLE : ST_READ_OUT;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Result valid: set when a read finishes, cleared when the word is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_READ_OUT && rsp_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   // State and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_READ_OUT && rsp_free) begin
            rsp_cell_ff <= cell_ff;
            rsp_acc_ff  <= cell_ok ? acc_rd : '0;
            rsp_ovf_ff  <= cell_ok && sat_rd;
         end
      end
   end

   // Item capture.
   always_ff @(posedge clock) begin
      if (req_take) begin
         cell_ff <= req_cell_index;
         lc_ff   <= req_lower_cell;
         uc_ff   <= req_upper_cell;
         diag_ff <= req_diag_value;
         x_ff    <= req_x_value;
         init_ff <= req_acc_init;
         lo_ff   <= req_lower_coeff;
         up_ff   <= req_upper_coeff;
      end
   end

   // Multiplier operands and store controls for each step.
   always_comb begin
      mul_en            = 1'b0;
      mul_a             = diag_ff;
      mul_b             = x_ff;
      acc_term          = prod;
      x_ctl.wr_en       = 1'b0;
      x_ctl.wr_addr     = ADDR_W'(cell_ff);
      x_ctl.rd_en       = 1'b0;
      x_ctl.rd_addr_a   = ADDR_W'(lc_ff);
      x_ctl.rd_addr_b   = ADDR_W'(uc_ff);
      acc_ctl.rd_en     = 1'b0;
      acc_ctl.wr_en     = 1'b0;
      acc_ctl.load      = 1'b0;
      acc_ctl.addr      = ADDR_W'(cell_ff);
      case (state_ff)
         ST_LOAD_MUL: begin
            x_ctl.wr_en = cell_ok;
            mul_en      = 1'b1;
         end
         ST_LOAD_WR: begin
            acc_ctl.wr_en = cell_ok;
            acc_ctl.load  = 1'b1;
            acc_term      = incl_diag_ff ? prod : '0;
         end
         ST_FACE_RDX: begin
            x_ctl.rd_en   = 1'b1;
            acc_ctl.rd_en = 1'b1;
            acc_ctl.addr  = ADDR_W'(uc_ff);
         end
         ST_FACE_MUL1: begin
            mul_en = 1'b1;
            mul_a  = cu;
            mul_b  = xl;
         end
         ST_FACE_WR1: begin
            acc_ctl.wr_en = uc_ok;
            acc_ctl.addr  = ADDR_W'(uc_ff);
            mul_en        = 1'b1;
            mul_a         = cl;
            mul_b         = xu;
         end
         ST_FACE_RD2: begin
            acc_ctl.rd_en = 1'b1;
            acc_ctl.addr  = ADDR_W'(lc_ff);
         end
         ST_FACE_WR2: begin
            acc_ctl.wr_en = lc_ok;
            acc_ctl.addr  = ADDR_W'(lc_ff);
         end
         ST_READ_RD: begin
            acc_ctl.rd_en = 1'b1;
         end
         default: ;
      endcase
   end

   ldu_mul_unit u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   ldu_x_bank u_x_bank (
      .clock     (clock),
      .ctl       (x_ctl),
      .wr_data   (x_ff),
      .rd_data_a (x_rd_a),
      .rd_data_b (x_rd_b)
   );

   ldu_acc_bank u_acc_bank (
      .clock  (clock),
      .ctl    (acc_ctl),
      .term   (acc_term),
      .init   (init_ff),
      .rd_acc (acc_rd),
      .rd_sat (sat_rd)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_cell = rsp_cell_ff;
   assign rsp_acc_value = rsp_acc_ff;
   assign rsp_overflow  = rsp_ovf_ff;

   // A face under a non-diagonal kind starts by reading both x values.
   a_face_start : assert property (@(posedge clock) disable iff (reset)
      (req_take && req_mode == MODE_FACE && kind_ff != KIND_DIAG)
      |=> state_ff == ST_FACE_RDX)
      else $error("face item did not start its x read");

   // The accumulator store is written only in the write steps.
   a_acc_write_step : assert property (@(posedge clock) disable iff (reset)
      acc_ctl.wr_en |-> (state_ff == ST_LOAD_WR || state_ff == ST_FACE_WR1 ||
                         state_ff == ST_FACE_WR2))
      else $error("accumulator written outside a write step");

   // A result word appears only at the end of a read item.
   a_rsp_from_read : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff) == ST_READ_OUT)
      else $error("result word not caused by a read item");

endmodule
